// ===== design/swnq_pkg.sv =====
// shared types, constants and helpers for the skin weight normaliser
`timescale 1ns / 1ps
package swnq_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int QUEUE_DEPTH     = 4;
   localparam int WEIGHT_W        = 21;
   localparam int BONE_W          = 8;
   localparam int VNUM_W          = 24;
   localparam int ECNT_W          = 5;
   localparam int QUANT_W         = 8;
   localparam int TOL_W           = 16;
   localparam int ONE_Q16         = 65536;
   localparam int SCALE2          = 510;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd3277;

   typedef struct packed {
      logic                       is_pair;
      logic [BONE_W-1:0]          bone;
      logic signed [WEIGHT_W-1:0] weight;
      logic                       last;
   } qent_type;

   typedef struct packed {
      logic [BONE_W-1:0]          bone;
      logic signed [WEIGHT_W-1:0] weight;
   } ent_type;

   typedef struct packed {
      logic [VNUM_W-1:0]  vertex_number;
      logic [ECNT_W-1:0]  entry_count;
      logic [BONE_W-1:0]  out_bone;
      logic [QUANT_W-1:0] quant_weight;
      logic               nonpositive_flag;
      logic               sum_warning;
      logic               last_out;
   } rsp_payload_type;

   function automatic logic signed [WEIGHT_W-1:0] sat_add(
      input logic signed [WEIGHT_W-1:0] a,
      input logic signed [WEIGHT_W-1:0] b);
      logic signed [WEIGHT_W:0] s;
      logic signed [WEIGHT_W:0] hi;
      logic signed [WEIGHT_W:0] lo;
      s  = (WEIGHT_W+1)'(a) + (WEIGHT_W+1)'(b);
      hi = (WEIGHT_W+1)'({1'b0, {(WEIGHT_W-1){1'b1}}});
      lo = -hi - (WEIGHT_W+1)'(1);
      if (s > hi) begin
         return hi[WEIGHT_W-1:0];
      end else if (s < lo) begin
         return lo[WEIGHT_W-1:0];
      end
      return s[WEIGHT_W-1:0];
   endfunction

endpackage

// ===== design/swnq_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
interface swnq_req_if;
   import swnq_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       has_entry;
   logic [BONE_W-1:0]          bone_index;
   logic signed [WEIGHT_W-1:0] weight;
   logic                       last;
   modport source (output valid, has_entry, bone_index, weight, last, input ready);
   modport sink   (input valid, has_entry, bone_index, weight, last, output ready);
endinterface

interface swnq_rsp_if;
   import swnq_pkg::*;
   logic               valid;
   logic               ready;
   logic [VNUM_W-1:0]  vertex_number;
   logic [ECNT_W-1:0]  entry_count;
   logic [BONE_W-1:0]  out_bone;
   logic [QUANT_W-1:0] quant_weight;
   logic               nonpositive_flag;
   logic               sum_warning;
   logic               last_out;
   modport source (output valid, vertex_number, entry_count, out_bone, quant_weight,
                   nonpositive_flag, sum_warning, last_out, input ready);
   modport sink   (input valid, vertex_number, entry_count, out_bone, quant_weight,
                   nonpositive_flag, sum_warning, last_out, output ready);
endinterface

// ===== design/skin_weight_normalize_quantize.sv =====
// top level of the skin weight normaliser and 8-bit quantiser
`timescale 1ns / 1ps
// Usage: bone/weight pairs of one vertex arrive on req, one beat each, the
// final beat carries last. A beat with has_entry low and last low is taken
// and dropped; pairs beyond MAX_ENTRIES are dropped, their last mark kept.
// The front takes a beat every cycle while its four-deep queue has room.
// The back loads the vertex into a small ram, then merges duplicates by
// pairwise bone compares, sums the entries and emits each entry after a
// restoring divide. The merge scan and the single shared divider set the
// cost of a vertex in the back; it loads another vertex only once the last
// entry of this one is in the output register.
// rsp carries one beat per merged entry from an output register; while rsp
// is stalled the back holds and the queue keeps taking beats until full.
// csr_we writes sum_tolerance; write only while idle.
// Reset (synchronous) clears the queue, counts and vertex number and sets
// sum_tolerance to 3277.
module skin_weight_normalize_quantize #(
   parameter int MAX_ENTRIES = swnq_pkg::MAX_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [swnq_pkg::TOL_W-1:0] csr_wdata,
   swnq_req_if.sink                   req,
   swnq_rsp_if.source                 rsp
);
   import swnq_pkg::*;

   logic [TOL_W-1:0] tol_ff, tol_in;
   logic             q_push, q_pop, q_full, q_empty;
   qent_type         q_din, q_dout;

   assign tol_in = csr_we ? csr_wdata : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   swnq_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_din)
   );

   swnq_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   swnq_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock   (clock),
      .reset   (reset),
      .tol     (tol_ff),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .q_data  (q_dout),
      .rsp     (rsp)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("queue pop while empty");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.nonpositive_flag |-> rsp.quant_weight == '0)
      else $error("flagged entry with nonzero weight");
endmodule

// ===== design/swnq_ram.sv =====
// generic ram, one write port, two registered read ports
`timescale 1ns / 1ps
module swnq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

// ===== design/swnq_queue.sv =====
// short fifo between front and back
`timescale 1ns / 1ps
module swnq_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  swnq_pkg::qent_type din,
   output logic               full,
   input  logic               pop,
   output swnq_pkg::qent_type dout,
   output logic               empty
);
   import swnq_pkg::*;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   qent_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == CW'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? PW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? PW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = CW'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= din;
      end
   end
endmodule

// ===== design/swnq_front.sv =====
// front: accepts beats, drops overflow pairs, queues pairs and vertex ends
`timescale 1ns / 1ps
module swnq_front #(
   parameter int MAX_ENTRIES = swnq_pkg::MAX_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   swnq_req_if.sink           req,
   input  logic               q_full,
   output logic               q_push,
   output swnq_pkg::qent_type q_data
);
   import swnq_pkg::*;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          take, room;

   assign req.ready = !q_full;
   assign take      = req.valid && req.ready;
   assign room      = (count_ff < CW'(MAX_ENTRIES));

   always_comb begin
      q_data.is_pair = req.has_entry && room;
      q_data.bone    = req.bone_index;
      q_data.weight  = req.weight;
      q_data.last    = req.last;
      q_push         = take && (q_data.is_pair || req.last);
      count_in       = count_ff;
      if (take) begin
         if (req.last) begin
            count_in = '0;
         end else if (q_data.is_pair) begin
            count_in = CW'(count_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

// ===== design/swnq_back.sv =====
// back: merge, sum, tolerance check, divide and emit per vertex
`timescale 1ns / 1ps
module swnq_back #(
   parameter int MAX_ENTRIES = swnq_pkg::MAX_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [swnq_pkg::TOL_W-1:0]  tol,
   input  logic                        q_empty,
   output logic                        q_pop,
   input  swnq_pkg::qent_type          q_data,
   swnq_rsp_if.source                  rsp
);
   import swnq_pkg::*;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int SW = WEIGHT_W + AW;
   localparam int NW = SW + 10;
   localparam int EW = $bits(ent_type);

   localparam logic [3:0] ST_LOAD  = 4'd0;
   localparam logic [3:0] ST_M_RD  = 4'd1;
   localparam logic [3:0] ST_M_CMP = 4'd2;
   localparam logic [3:0] ST_M_MV  = 4'd3;
   localparam logic [3:0] ST_S_RD  = 4'd4;
   localparam logic [3:0] ST_S_ACC = 4'd5;
   localparam logic [3:0] ST_CHK   = 4'd6;
   localparam logic [3:0] ST_O_RD  = 4'd7;
   localparam logic [3:0] ST_O_LD  = 4'd8;
   localparam logic [3:0] ST_O_DIV = 4'd9;
   localparam logic [3:0] ST_O_OUT = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       n_ff, n_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [SW-1:0]       sum_ff, sum_in, dev;
   logic                warn_ff, warn_in;
   logic [VNUM_W-1:0]   vnum_ff, vnum_in;
   logic [BONE_W-1:0]   bone_ff, bone_in;
   logic                flag_ff, flag_in;
   logic [NW-1:0]       rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QUANT_W-1:0]  quo_ff, quo_in;
   logic [3:0]          cnt_ff, cnt_in;
   rsp_payload_type     out_ff, out_in;
   logic                ov_ff, ov_in;
   logic                out_free;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr_a, rd_addr_b;
   ent_type             wr_ent, ent_a, ent_b;
   logic [EW-1:0]       rd_data_a, rd_data_b;
   logic [WEIGHT_W-2:0] wpos;
   logic [28:0]         prod;

   swnq_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_ent),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign ent_a    = ent_type'(rd_data_a);
   assign ent_b    = ent_type'(rd_data_b);
   assign wpos     = (ent_a.weight > 0) ? ent_a.weight[WEIGHT_W-2:0] : '0;
   assign prod     = wpos * 9'(SCALE2);
   assign out_free = !ov_ff || rsp.ready;
   assign dev      = (sum_ff >= SW'(ONE_Q16)) ? SW'(sum_ff - SW'(ONE_Q16))
                                              : SW'(SW'(ONE_Q16) - sum_ff);

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      sum_in    = sum_ff;
      warn_in   = warn_ff;
      vnum_in   = vnum_ff;
      bone_in   = bone_ff;
      flag_in   = flag_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      out_in    = out_ff;
      ov_in     = rsp.ready ? 1'b0 : ov_ff;
      q_pop     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = n_ff[AW-1:0];
      wr_ent    = '{bone: q_data.bone, weight: q_data.weight};
      rd_addr_a = i_ff[AW-1:0];
      rd_addr_b = j_ff[AW-1:0];
      unique case (state_ff)
         ST_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_data.is_pair) begin
                  wr_en = 1'b1;
                  n_in  = CW'(n_ff + 1'b1);
               end
               if (q_data.last) begin
                  i_in     = CW'(1);
                  j_in     = '0;
                  state_in = ST_M_RD;
               end
            end
         end
         ST_M_RD: begin
            if (i_ff >= n_ff) begin
               k_in     = '0;
               sum_in   = '0;
               state_in = ST_S_RD;
            end else if (j_ff == i_ff) begin
               i_in = CW'(i_ff + 1'b1);
               j_in = '0;
            end else begin
               state_in = ST_M_CMP;
            end
         end
         ST_M_CMP: begin
            if (ent_a.bone == ent_b.bone) begin
               wr_en     = 1'b1;
               wr_addr   = j_ff[AW-1:0];
               wr_ent    = '{bone: ent_b.bone, weight: sat_add(ent_b.weight, ent_a.weight)};
               n_in      = CW'(n_ff - 1'b1);
               rd_addr_a = n_in[AW-1:0];
               state_in  = ST_M_MV;
            end else begin
               j_in     = CW'(j_ff + 1'b1);
               state_in = ST_M_RD;
            end
         end
         ST_M_MV: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff[AW-1:0];
            wr_ent   = ent_a;
            j_in     = '0;
            state_in = ST_M_RD;
         end
         ST_S_RD: begin
            rd_addr_a = k_ff[AW-1:0];
            state_in  = (k_ff >= n_ff) ? ST_CHK : ST_S_ACC;
         end
         ST_S_ACC: begin
            sum_in   = SW'(sum_ff + SW'(wpos));
            k_in     = CW'(k_ff + 1'b1);
            state_in = ST_S_RD;
         end
         ST_CHK: begin
            warn_in  = dev > SW'(tol);
            k_in     = '0;
            state_in = ST_O_RD;
         end
         ST_O_RD: begin
            rd_addr_a = k_ff[AW-1:0];
            state_in  = (k_ff >= n_ff) ? ST_DONE : ST_O_LD;
         end
         ST_O_LD: begin
            bone_in  = ent_a.bone;
            flag_in  = !(ent_a.weight > 0);
            rem_in   = NW'(prod) + NW'(sum_ff);
            dsh_in   = NW'({sum_ff, 8'd0});
            quo_in   = '0;
            cnt_in   = 4'(QUANT_W);
            state_in = ST_O_DIV;
         end
         ST_O_DIV: begin
            // restoring divide, one quotient bit a cycle
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               quo_in = {quo_ff[QUANT_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QUANT_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               state_in = ST_O_OUT;
            end
         end
         ST_O_OUT: begin
            if (out_free) begin
               out_in.vertex_number    = vnum_ff;
               out_in.entry_count      = ECNT_W'(n_ff);
               out_in.out_bone         = bone_ff;
               out_in.quant_weight     = (sum_ff == '0) ? '0 : quo_ff;
               out_in.nonpositive_flag = flag_ff;
               out_in.sum_warning      = warn_ff;
               out_in.last_out         = (CW'(k_ff + 1'b1) == n_ff);
               ov_in                   = 1'b1;
               k_in                    = CW'(k_ff + 1'b1);
               state_in                = ST_O_RD;
            end
         end
         ST_DONE: begin
            vnum_in  = VNUM_W'(vnum_ff + 1'b1);
            n_in     = '0;
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         n_ff     <= '0;
         vnum_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         vnum_ff  <= vnum_in;
         ov_ff    <= ov_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      sum_ff  <= sum_in;
      warn_ff <= warn_in;
      bone_ff <= bone_in;
      flag_ff <= flag_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      out_ff  <= out_in;
   end

   assign rsp.valid            = ov_ff;
   assign rsp.vertex_number    = out_ff.vertex_number;
   assign rsp.entry_count      = out_ff.entry_count;
   assign rsp.out_bone         = out_ff.out_bone;
   assign rsp.quant_weight     = out_ff.quant_weight;
   assign rsp.nonpositive_flag = out_ff.nonpositive_flag;
   assign rsp.sum_warning      = out_ff.sum_warning;
   assign rsp.last_out         = out_ff.last_out;
endmodule
